[src/ssmv_pkg.sv]
// Shared types, codes and fixed-point helpers for the symmetric CSR SpMV block.
// No dependencies; compiled first.
package ssmv_pkg;

	localparam int MAX_ROWS_DEF    = 1024;
	localparam int MAX_ENTRIES_DEF = 8192;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int FRAC_BITS       = 16;

	localparam int FUNC_W   = 3;
	localparam int SLOT_W   = 13;
	localparam int COLUMN_W = 10;
	localparam int POINTER_W = 14;
	localparam int VALUE_W  = 32;
	localparam int DOT_W    = 64;
	localparam int STATUS_W = 2;
	localparam int ROWCNT_W = 11;
	localparam int PADDR_W  = 3;

	localparam logic [FUNC_W-1:0] FUNC_ROW_PTR = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENTRY   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_X       = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RESULT  = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RUN     = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_DIAG  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_LOWER    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_SATURATE = 2'd3;

	localparam logic KIND_RUN  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic REG_ROW_COUNT  = 1'b0;
	localparam logic REG_CLEAR_MODE = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR, S_ROW_A, S_ROW_B, S_ROW_C, S_ROW_D, S_ROW_E,
		S_ENT_A, S_ENT_B, S_ENT_C, S_ADD_T, S_OFF_A, S_OFF_B, S_OFF_C,
		S_ROW_END, S_DOT, S_RD_A, S_RD_B, S_OUT
	} state_t;

	// Round a product with 2*FRAC_BITS fraction bits back to FRAC_BITS bits,
	// to nearest with ties toward positive infinity.
	function automatic logic signed [63:0] round_prod(input logic signed [63:0] p);
		return (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	function automatic logic [STATUS_W-1:0] raise(input logic [STATUS_W-1:0] cur,
		input logic [STATUS_W-1:0] code);
		return (code > cur) ? code : cur;
	endfunction

endpackage

[src/ssmv_in_if.sv]
// Input channel of the SpMV block: valid/ready handshake with the load/command beat.
// Depends on ssmv_pkg.
interface ssmv_in_if;
	logic                          valid;
	logic                          ready;
	logic [ssmv_pkg::FUNC_W-1:0]    func;
	logic [ssmv_pkg::SLOT_W-1:0]    slot;
	logic [ssmv_pkg::COLUMN_W-1:0]  column;
	logic [ssmv_pkg::POINTER_W-1:0] pointer;
	logic signed [ssmv_pkg::VALUE_W-1:0] value;

	modport source (output valid, func, slot, column, pointer, value, input ready);
	modport sink   (input valid, func, slot, column, pointer, value, output ready);
endinterface

[src/ssmv_out_if.sv]
// Result channel of the SpMV block: valid/ready handshake with the result beat.
// Depends on ssmv_pkg.
interface ssmv_out_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic signed [ssmv_pkg::VALUE_W-1:0] read_value;
	logic signed [ssmv_pkg::DOT_W-1:0]   dot;
	logic [ssmv_pkg::STATUS_W-1:0]       status;

	modport source (output valid, kind, read_value, dot, status, input ready);
	modport sink   (input valid, kind, read_value, dot, status, output ready);
endinterface

[src/symmetric_csr_spmv_dot.sv]
// Symmetric CSR sparse matrix-vector multiply with dot product, top level.
// Loads (func 0..3) are written when they are accepted; a read passes through S_RD_A, S_RD_B
// and S_OUT before its result beat, a read past the result store or a run with no rows straight to S_OUT.
// A run walks every row and its entries through the single shared multiplier and saturating adder
// and the RAM reads, then raises its beat from S_OUT.
// Reset (arst_n low, asynchronous) clears control state, row_count to 1, clear_mode,
// dot and status to 0; the matrix, x and result memories are undefined until written.
module symmetric_csr_spmv_dot #(
	parameter int MAX_ROWS    = ssmv_pkg::MAX_ROWS_DEF,
	parameter int MAX_ENTRIES = ssmv_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_BITS  = ssmv_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssmv_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	ssmv_in_if.sink                       items_in,
	ssmv_out_if.source                    results_out
);
	import ssmv_pkg::*;

	// Widths that follow from the sizes of the stores.
	localparam int IW  = $clog2(MAX_ROWS + 1);    // row counter, holds n
	localparam int RAW = $clog2(MAX_ROWS);        // x and result address
	localparam int EW  = $clog2(MAX_ENTRIES + 1); // entry pointer, holds MAX_ENTRIES
	localparam int EAW = $clog2(MAX_ENTRIES);     // entry address
	localparam int PW  = 2 * VALUE_BITS;          // exact product
	localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN = -VMAX - 64'sd1;

	// Configuration registers. Writes complete in the access phase; pready is tied high.
	logic [ROWCNT_W-1:0] row_count_q;
	logic                clear_mode_q;
	logic                cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q  <= ROWCNT_W'(1);
			clear_mode_q <= 1'b0;
		end else if (cfg_we) begin
			if (paddr[2] == REG_ROW_COUNT) row_count_q <= pwdata[ROWCNT_W-1:0];
			else clear_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_ROW_COUNT) prdata = 32'(row_count_q);
		else prdata = 32'(clear_mode_q);
	end

	// Sequencer and datapath registers.
	state_t state_q, state_d;
	logic [IW-1:0]        i_q, n_q, n_cfg;
	logic [EW-1:0]        lo_q, hi_q, k_q, ptr_clamped;
	logic                 first_q;
	logic [COLUMN_W-1:0]  c_q;
	logic signed [VALUE_BITS-1:0] a_q, xi_q, t_q, rc_q;
	logic signed [PW-1:0] prod_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [STATUS_W-1:0]  st_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 kind_q;
	logic signed [VALUE_BITS-1:0] rv_q;

	logic out_valid_q, out_kind_q;
	logic signed [VALUE_W-1:0] out_rv_q;
	logic signed [DOT_W-1:0]   out_dot_q;
	logic [STATUS_W-1:0]       out_st_q;

	logic accept, out_free;
	assign items_in.ready = (state_q == S_IDLE);
	assign accept   = items_in.valid && items_in.ready;
	assign out_free = !out_valid_q || results_out.ready;

	assign n_cfg = (32'(row_count_q) > 32'(MAX_ROWS)) ? IW'(MAX_ROWS) : IW'(row_count_q);

	// Memories.
	logic                  rp_we;
	logic [IW-1:0]         rp_waddr, rp_raddr;
	logic [POINTER_W-1:0]  rp_rdata;
	logic                  ent_we;
	logic [EAW-1:0]        ent_waddr, ent_raddr;
	logic [COLUMN_W-1:0]   col_rdata;
	logic [VALUE_BITS-1:0] coef_rdata;
	logic                  x_we;
	logic [RAW-1:0]        x_waddr, x_raddr;
	logic [VALUE_BITS-1:0] x_rdata;
	logic                  r_we;
	logic [RAW-1:0]        r_waddr, r_raddr;
	logic [VALUE_BITS-1:0] r_wdata, r_rdata;

	ssmv_ram #(.WIDTH(POINTER_W), .DEPTH(MAX_ROWS + 1)) u_rp_ram (
		.clk, .we(rp_we), .waddr(rp_waddr), .wdata(items_in.pointer),
		.raddr(rp_raddr), .rdata(rp_rdata));
	ssmv_ram #(.WIDTH(COLUMN_W), .DEPTH(MAX_ENTRIES)) u_col_ram (
		.clk, .we(ent_we), .waddr(ent_waddr), .wdata(items_in.column),
		.raddr(ent_raddr), .rdata(col_rdata));
	ssmv_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_coef_ram (
		.clk, .we(ent_we), .waddr(ent_waddr), .wdata(items_in.value[VALUE_BITS-1:0]),
		.raddr(ent_raddr), .rdata(coef_rdata));
	ssmv_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROWS)) u_x_ram (
		.clk, .we(x_we), .waddr(x_waddr), .wdata(items_in.value[VALUE_BITS-1:0]),
		.raddr(x_raddr), .rdata(x_rdata));
	ssmv_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ROWS)) u_r_ram (
		.clk, .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata));

	// Entry classification for the current entry.
	logic is_diag, is_bad;
	assign is_diag = (32'(c_q) == 32'(i_q));
	assign is_bad  = (32'(c_q) < 32'(i_q)) || (32'(c_q) >= 32'(n_q));

	// The shared multiplier. Its operands are picked by state; the product is
	// always registered before the adder uses it.
	logic signed [VALUE_BITS-1:0] mul_a, mul_b;
	always_comb begin
		mul_a = a_q;
		mul_b = xi_q;
		case (state_q)
			S_OFF_A:   mul_b = $signed(x_rdata);
			S_ROW_END: mul_a = t_q;
			default:   ;
		endcase
	end

	// The shared saturating adder: rounded product into t, or into the
	// mirrored result element during the scatter step.
	logic signed [VALUE_BITS-1:0] add_base, add_res;
	logic signed [63:0]           add_sum;
	logic                         add_sat;
	assign add_base = (state_q == S_OFF_C) ? rc_q : t_q;
	assign add_sum  = 64'(add_base) + round_prod(64'(prod_q));
	always_comb begin
		add_sat = 1'b1;
		if (add_sum > VMAX) add_res = VMAX[VALUE_BITS-1:0];
		else if (add_sum < VMIN) add_res = VMIN[VALUE_BITS-1:0];
		else begin
			add_res = add_sum[VALUE_BITS-1:0];
			add_sat = 1'b0;
		end
	end

	// Dot accumulator add, saturating to 64 bits.
	logic signed [DOT_W:0]   dot_sum;
	logic signed [DOT_W-1:0] dot_res;
	logic                    dot_sat;
	assign dot_sum = (DOT_W + 1)'(dot_q) + (DOT_W + 1)'(prod_q);
	always_comb begin
		dot_sat = (dot_sum[DOT_W] != dot_sum[DOT_W-1]);
		if (dot_sat) dot_res = dot_sum[DOT_W] ? {1'b1, {(DOT_W - 1){1'b0}}}
			: {1'b0, {(DOT_W - 1){1'b1}}};
		else dot_res = dot_sum[DOT_W-1:0];
	end

	assign ptr_clamped = (32'(rp_rdata) > 32'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES)
		: EW'(rp_rdata);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (items_in.func == FUNC_RUN) begin
						if (n_cfg == '0) state_d = S_OUT;
						else if (clear_mode_q) state_d = S_CLR;
						else state_d = S_ROW_A;
					end else if (items_in.func == FUNC_READ) begin
						if (32'(items_in.slot) < 32'(MAX_ROWS)) state_d = S_RD_A;
						else state_d = S_OUT;
					end
				end
			end
			S_CLR:     if (i_q + IW'(1) == n_q) state_d = S_ROW_A;
			S_ROW_A:   state_d = S_ROW_B;
			S_ROW_B:   state_d = S_ROW_C;
			S_ROW_C:   state_d = S_ROW_D;
			S_ROW_D:   state_d = S_ROW_E;
			S_ROW_E:   state_d = S_ENT_A;
			S_ENT_A:   state_d = (k_q < hi_q) ? S_ENT_B : S_ROW_END;
			S_ENT_B:   state_d = S_ENT_C;
			S_ENT_C: begin
				if (is_diag) state_d = S_ADD_T;
				else if (is_bad) state_d = S_ENT_A;
				else state_d = S_OFF_A;
			end
			S_ADD_T:   state_d = S_ENT_A;
			S_OFF_A:   state_d = S_OFF_B;
			S_OFF_B:   state_d = S_OFF_C;
			S_OFF_C:   state_d = S_ENT_A;
			S_ROW_END: state_d = S_DOT;
			S_DOT:     state_d = (i_q + IW'(1) == n_q) ? S_OUT : S_ROW_A;
			S_RD_A:    state_d = S_RD_B;
			S_RD_B:    state_d = S_OUT;
			S_OUT:     if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		rp_we     = accept && (items_in.func == FUNC_ROW_PTR)
			&& (32'(items_in.slot) <= 32'(MAX_ROWS));
		rp_waddr  = IW'(items_in.slot);
		rp_raddr  = (state_q == S_ROW_B) ? i_q + IW'(1) : i_q;
		ent_we    = accept && (items_in.func == FUNC_ENTRY)
			&& (32'(items_in.slot) < 32'(MAX_ENTRIES));
		ent_waddr = EAW'(items_in.slot);
		ent_raddr = k_q[EAW-1:0];
		x_we      = accept && (items_in.func == FUNC_X)
			&& (32'(items_in.slot) < 32'(MAX_ROWS));
		x_waddr   = RAW'(items_in.slot);
		x_raddr   = (state_q == S_ENT_C) ? RAW'(c_q) : i_q[RAW-1:0];
		r_we      = 1'b0;
		r_waddr   = RAW'(items_in.slot);
		r_wdata   = items_in.value[VALUE_BITS-1:0];
		r_raddr   = i_q[RAW-1:0];
		case (state_q)
			S_IDLE: r_we = accept && (items_in.func == FUNC_RESULT)
				&& (32'(items_in.slot) < 32'(MAX_ROWS));
			S_CLR: begin
				r_we    = 1'b1;
				r_waddr = i_q[RAW-1:0];
				r_wdata = '0;
			end
			S_OFF_A: r_raddr = RAW'(c_q);
			S_OFF_C: begin
				r_we    = 1'b1;
				r_waddr = RAW'(c_q);
				r_wdata = add_res;
			end
			S_ROW_END: begin
				r_we    = 1'b1;
				r_waddr = i_q[RAW-1:0];
				r_wdata = t_q;
			end
			S_RD_A: r_raddr = RAW'(slot_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dot_q   <= '0;
			st_q    <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new beat is loaded from the output state once the register is free;
			// otherwise the held beat drops when the sink takes it.
			if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
			else if (results_out.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (accept && items_in.func == FUNC_RUN) begin
					dot_q <= '0;
					st_q  <= STAT_OK;
				end
				S_ENT_A: if (!(k_q < hi_q) && first_q) st_q <= raise(st_q, STAT_NO_DIAG);
				S_ENT_C: begin
					if (first_q && !is_diag)
						st_q <= raise(st_q, is_bad ? STAT_LOWER : STAT_NO_DIAG);
					else if (!is_diag && is_bad)
						st_q <= raise(st_q, STAT_LOWER);
				end
				S_ADD_T, S_OFF_B, S_OFF_C: if (add_sat) st_q <= raise(st_q, STAT_SATURATE);
				S_DOT: begin
					dot_q <= dot_res;
					if (dot_sat) st_q <= raise(st_q, STAT_SATURATE);
				end
				default: ;
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: if (accept) begin
				slot_q <= items_in.slot;
				n_q    <= n_cfg;
				i_q    <= '0;
				rv_q   <= '0;
				kind_q <= (items_in.func == FUNC_READ) ? KIND_READ : KIND_RUN;
			end
			S_CLR:   i_q  <= (i_q + IW'(1) == n_q) ? '0 : i_q + IW'(1);
			S_ROW_B: lo_q <= ptr_clamped;
			S_ROW_C: hi_q <= (ptr_clamped < lo_q) ? lo_q : ptr_clamped;
			S_ROW_D: xi_q <= $signed(x_rdata);
			S_ROW_E: begin
				t_q     <= $signed(r_rdata);
				k_q     <= lo_q;
				first_q <= 1'b1;
			end
			S_ENT_B: begin
				c_q <= col_rdata;
				a_q <= $signed(coef_rdata);
			end
			S_ENT_C: begin
				first_q <= 1'b0;
				if (!is_diag && is_bad) k_q <= k_q + EW'(1);
			end
			S_ADD_T: begin
				t_q <= add_res;
				k_q <= k_q + EW'(1);
			end
			S_OFF_B: begin
				t_q  <= add_res;
				rc_q <= $signed(r_rdata);
			end
			S_OFF_C: k_q <= k_q + EW'(1);
			S_DOT:   i_q <= i_q + IW'(1);
			S_RD_B:  rv_q <= $signed(r_rdata);
			S_OUT: if (out_free) begin
				out_kind_q <= kind_q;
				out_rv_q   <= VALUE_W'(rv_q);
				out_dot_q  <= dot_q;
				out_st_q   <= st_q;
			end
			default: ;
		endcase
	end

	assign results_out.valid      = out_valid_q;
	assign results_out.kind       = out_kind_q;
	assign results_out.read_value = out_rv_q;
	assign results_out.dot        = out_dot_q;
	assign results_out.status     = out_st_q;

	// An entry is only classified while it lies inside its row.
	a_entry_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ENT_C) |-> (k_q < hi_q))
		else $error("entry walked past the end of its row");

	// A scatter only ever goes to a later row.
	a_scatter_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OFF_C) |-> (32'(c_q) > 32'(i_q)) && (32'(c_q) < 32'(n_q)))
		else $error("scatter to a row that is not ahead of the current one");

	// A new result beat is only raised from the output state.
	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results_out.valid) |-> ($past(state_q) == S_OUT))
		else $error("result beat raised outside the output state");

endmodule

[src/ssmv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
